### src/assert_macros.svh
// Assertion macros used by the checker file of the project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off while in reset
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off while in reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/jsu_pkg.sv
// Shared types and constants of the JSON string unescaper.
`timescale 1ns / 1ps
`default_nettype none

package jsu_pkg;

    // What a result word carries
    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_END  = 2'd1,
        KIND_ERR  = 2'd2
    } kind_t;

    // Escape decoding phase
    typedef enum logic [2:0] {
        PH_PLAIN = 3'd0,
        PH_ESC   = 3'd1,
        PH_HEX1  = 3'd2,
        PH_HEX2  = 3'd3,
        PH_HEX3  = 3'd4,
        PH_HEX4  = 3'd5
    } phase_t;

    // Characters of interest
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;

    // Control bytes the short escapes map to
    localparam logic [7:0] CTL_BS  = 8'h08;
    localparam logic [7:0] CTL_FF  = 8'h0C;
    localparam logic [7:0] CTL_LF  = 8'h0A;
    localparam logic [7:0] CTL_CR  = 8'h0D;
    localparam logic [7:0] CTL_TAB = 8'h09;

    // Results caused by one input byte (one to three words)
    typedef struct packed {
        logic       has_res;
        logic [1:0] last_idx;
        kind_t      kind;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
    } res_set_t;

endpackage

`default_nettype wire

### src/jsu_decode.sv
// Combinational decode of one input byte against the escape state.
`timescale 1ns / 1ps
`default_nettype none

module jsu_decode (
    input  wire logic [7:0]       byte_in,
    input  wire jsu_pkg::phase_t  phase,
    input  wire logic [11:0]      accum,
    input  wire logic             allow_upper_hex,
    output jsu_pkg::res_set_t     res,
    output jsu_pkg::phase_t       phase_next,
    output logic [11:0]           accum_next
);
    import jsu_pkg::*;

    logic        hex_ok;
    logic [3:0]  hex_val;
    logic [15:0] code;

    // Hex digit value; letters have low nibble 1..6
    always_comb begin
        hex_ok  = 1'b0;
        hex_val = byte_in[3:0];
        if (byte_in inside {[8'h30:8'h39]}) begin
            hex_ok = 1'b1;
        end else if (byte_in inside {[8'h61:8'h66]}) begin
            hex_ok  = 1'b1;
            hex_val = byte_in[3:0] + 4'd9;
        end else if (allow_upper_hex && (byte_in inside {[8'h41:8'h46]})) begin
            hex_ok  = 1'b1;
            hex_val = byte_in[3:0] + 4'd9;
        end
    end

    assign code = {accum, hex_val};

    // Phase walk and result build
    always_comb begin
        res         = '0;
        res.kind    = KIND_DATA;
        phase_next  = PH_PLAIN;
        accum_next  = accum;
        case (phase)
            PH_ESC: begin
                res.has_res = 1'b1;
                case (byte_in)
                    CH_QUOTE:  res.b0 = CH_QUOTE;
                    CH_BSLASH: res.b0 = CH_BSLASH;
                    CH_SLASH:  res.b0 = CH_SLASH;
                    CH_B:      res.b0 = CTL_BS;
                    CH_F:      res.b0 = CTL_FF;
                    CH_N:      res.b0 = CTL_LF;
                    CH_R:      res.b0 = CTL_CR;
                    CH_T:      res.b0 = CTL_TAB;
                    CH_U: begin
                        res.has_res = 1'b0;
                        phase_next  = PH_HEX1;
                        accum_next  = '0;
                    end
                    default: begin
                        res.kind   = KIND_ERR;
                        accum_next = '0;
                    end
                endcase
            end
            PH_HEX1, PH_HEX2, PH_HEX3: begin
                if (hex_ok) begin
                    accum_next = {accum[7:0], hex_val};
                    phase_next = phase_t'(phase + 3'd1);
                end else begin
                    res.has_res = 1'b1;
                    res.kind    = KIND_ERR;
                    accum_next  = '0;
                end
            end
            PH_HEX4: begin
                res.has_res = 1'b1;
                accum_next  = '0;
                if (!hex_ok) begin
                    res.kind = KIND_ERR;
                end else if (code[15:7] == 9'd0) begin
                    res.b0 = {1'b0, code[6:0]};
                end else if (code[15:11] == 5'd0) begin
                    res.last_idx = 2'd1;
                    res.b0       = {3'b110, code[10:6]};
                    res.b1       = {2'b10, code[5:0]};
                end else begin
                    res.last_idx = 2'd2;
                    res.b0       = {4'b1110, code[15:12]};
                    res.b1       = {2'b10, code[11:6]};
                    res.b2       = {2'b10, code[5:0]};
                end
            end
            default: begin
                // plain text
                if (byte_in == CH_BSLASH) begin
                    phase_next = PH_ESC;
                end else if (byte_in == CH_QUOTE) begin
                    res.has_res = 1'b1;
                    res.kind    = KIND_END;
                    accum_next  = '0;
                end else begin
                    res.has_res = 1'b1;
                    res.b0      = byte_in;
                end
            end
        endcase
    end

endmodule

`default_nettype wire

### src/jsu_out_buf.sv
// Result register: holds the words of one input byte and hands them out in turn.
`timescale 1ns / 1ps
`default_nettype none

module jsu_out_buf (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              load,
    input  wire jsu_pkg::res_set_t res,
    output logic                   free,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [7:0]             m_tdata,   // [7:0] out_byte
    output logic [1:0]             m_tuser,   // [1:0] kind
    output logic                   m_tlast
);
    import jsu_pkg::*;

    logic       valid_reg, valid_next;
    logic [1:0] pos_reg, pos_next;
    logic [1:0] last_reg;
    kind_t      kind_reg;
    logic [7:0] byte_reg [3];
    logic       at_last;
    logic       take;

    assign at_last = (pos_reg == last_reg);
    assign take    = valid_reg && m_tready;
    // free for a new set once the final word of the current one leaves
    assign free    = !valid_reg || (take && at_last);

    // control: word pointer and valid
    always_comb begin
        valid_next = valid_reg;
        pos_next   = pos_reg;
        if (load) begin
            valid_next = 1'b1;
            pos_next   = 2'd0;
        end else if (take) begin
            if (at_last) begin
                valid_next = 1'b0;
            end else begin
                pos_next = pos_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            pos_reg   <= 2'd0;
        end else begin
            valid_reg <= valid_next;
            pos_reg   <= pos_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (load) begin
            last_reg    <= res.last_idx;
            kind_reg    <= res.kind;
            byte_reg[0] <= res.b0;
            byte_reg[1] <= res.b1;
            byte_reg[2] <= res.b2;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = byte_reg[pos_reg];
    assign m_tuser  = kind_reg;
    assign m_tlast  = at_last;

endmodule

`default_nettype wire

### src/json_string_unescape_core.sv
// Top level of the JSON string unescaper: input register, escape state, result register.
// Takes the body of a JSON string one byte per word after the opening quote and gives
// the unescaped bytes, a closing-quote marker (tuser 1) or an escape error (tuser 2);
// tlast marks the final word caused by an input byte. Input bytes are taken one per
// cycle unless the result register is busy: each byte passes through one input register,
// a combinational decode and a three-entry result register. A backslash and the first
// three \u digits give no word and never stall. The fourth \u digit gives 1 to 3 UTF-8
// bytes, sent one per cycle while tready is high, and such a byte holds the result
// register until its final word is taken. allow_upper_hex is written on the cfg_w
// channel, which is always ready, and must be changed only while the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module json_string_unescape_core (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    // input words
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,    // [7:0] byte_in
    // result words
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,    // [7:0] out_byte
    output logic [1:0]      m_tuser,    // [1:0] kind
    output logic            m_tlast,    // last
    // mode register write
    input  wire logic       cfg_wvalid,
    output logic            cfg_wready,
    input  wire logic [0:0] cfg_wdata   // [0] allow_upper_hex
);
    import jsu_pkg::*;

    logic        in_valid_reg, in_valid_next;
    logic [7:0]  in_byte_reg;
    phase_t      phase_reg, phase_next, dec_phase;
    logic [11:0] accum_reg, accum_next, dec_accum;
    logic        upper_reg, upper_next;
    res_set_t    dec_res;
    logic        buf_free;
    logic        advance;
    logic        load;

    // mode register
    assign cfg_wready = 1'b1;
    assign upper_next = (cfg_wvalid && cfg_wready) ? cfg_wdata[0] : upper_reg;

    jsu_decode u_decode (
        .byte_in         (in_byte_reg),
        .phase           (phase_reg),
        .accum           (accum_reg),
        .allow_upper_hex (upper_reg),
        .res             (dec_res),
        .phase_next      (dec_phase),
        .accum_next      (dec_accum)
    );

    // a silent byte never waits for the result register
    assign advance  = in_valid_reg && (!dec_res.has_res || buf_free);
    assign load     = advance && dec_res.has_res;
    assign s_tready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        phase_next    = phase_reg;
        accum_next    = accum_reg;
        if (advance) begin
            phase_next    = dec_phase;
            accum_next    = dec_accum;
            in_valid_next = 1'b0;
        end
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end
    end

    // control and escape state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            phase_reg    <= PH_PLAIN;
            accum_reg    <= '0;
            upper_reg    <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            phase_reg    <= phase_next;
            accum_reg    <= accum_next;
            upper_reg    <= upper_next;
        end
    end

    // input byte
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
    end

    jsu_out_buf u_out_buf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (load),
        .res      (dec_res),
        .free     (buf_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

### src/jsu_checker.sv
// Port-level checks on the result stream of the unescaper, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module jsu_checker (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       m_tvalid,
    input  wire logic       m_tready,
    input  wire logic [7:0] m_tdata,
    input  wire logic [1:0] m_tuser,
    input  wire logic       m_tlast
);
    import jsu_pkg::*;

    // a stalled word stays offered
    `ASSERT_NEXT(a_hold_valid, aclk, aresetn, m_tvalid && !m_tready, m_tvalid, "m_tvalid dropped while stalled")

    // a stalled word keeps its payload
    `ASSERT_NEXT(a_hold_data, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "payload changed while stalled")

    // end and error markers stand alone for their input byte
    `ASSERT_SAME(a_mark_last, aclk, aresetn, m_tvalid && (m_tuser != KIND_DATA), m_tlast, "marker word not last")

    // end and error markers carry a zero byte
    `ASSERT_SAME(a_mark_zero, aclk, aresetn, m_tvalid && (m_tuser != KIND_DATA), m_tdata == 8'd0, "marker word with non-zero byte")

endmodule

bind json_string_unescape_core jsu_checker u_jsu_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire

### tb/sv/json_string_unescape_core_tb.sv
// Self-checking testbench of the JSON string unescaper: byte stream in, decoded words out.
`timescale 1ns / 1ps

module json_string_unescape_core_tb;

    import jsu_pkg::*;

    // Hex digit characters not in the package
    localparam logic [7:0] CH_0  = 8'h30;
    localparam logic [7:0] CH_9  = 8'h39;
    localparam logic [7:0] CH_LA = 8'h61;
    localparam logic [7:0] CH_LF = 8'h66;
    localparam logic [7:0] CH_UA = 8'h41;
    localparam logic [7:0] CH_UF = 8'h46;

    localparam int HOLDOFF_CYCLES = 80;
    localparam int IDLE_SETTLE    = 6;      // covers the input and result registers and a margin
    localparam int FINAL_WAIT     = 20000;

    // One decoded result word
    typedef struct packed {
        logic [7:0] data;
        kind_t      kind;
        logic       last;
    } out_word_t;

    logic       aclk;
    logic       aresetn    = 1'b0;
    logic       s_tvalid   = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata    = 8'h00;
    logic       m_tvalid;
    logic       m_tready   = 1'b0;
    logic [7:0] m_tdata;    // [7:0] out_byte
    logic [1:0] m_tuser;    // [1:0] kind
    logic       m_tlast;
    logic       cfg_wvalid = 1'b0;
    logic       cfg_wready;
    logic [0:0] cfg_wdata  = 1'b0;

    // Stream traffic and bookkeeping
    logic [7:0]  string_bytes[$];
    out_word_t   unescaped_q[$];
    int unsigned bytes_queued   = 0;
    int unsigned bytes_accepted = 0;
    int unsigned mismatch_count = 0;
    int unsigned tx_idle_pct    = 0;
    int unsigned rx_stall_pct   = 0;
    logic        holdoff_armed  = 1'b0;
    logic        rx_hold        = 1'b0;

    // Predictor state: escape phase, gathered \u digits, mode bit
    phase_t      esc_phase = PH_PLAIN;
    logic [11:0] hex_acc   = '0;
    logic        upper_ok  = 1'b0;

    json_string_unescape_core u_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .cfg_wvalid (cfg_wvalid),
        .cfg_wready (cfg_wready),
        .cfg_wdata  (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Hard limit on run time
    initial begin
        #1000000;
        $display("status: fail");
        $finish;
    end

    task automatic flag_mismatch(input string what);
        mismatch_count++;
        $display("%0t mismatch: %s", $realtime, what);
    endtask

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------

    function automatic int hex_digit(input logic [7:0] c);
        if (c >= CH_0 && c <= CH_9)
            return int'(c - CH_0);
        if (c >= CH_LA && c <= CH_LF)
            return int'(c - CH_LA) + 10;
        if (upper_ok && c >= CH_UA && c <= CH_UF)
            return int'(c - CH_UA) + 10;
        return -1;
    endfunction

    // Queue n words of one kind; the final one carries last
    function automatic void emit(input int n, input kind_t k,
                                 input logic [7:0] b0, b1, b2);
        out_word_t w;
        for (int i = 0; i < n; i++) begin
            w.data = (i == 0) ? b0 : (i == 1) ? b1 : b2;
            w.kind = k;
            w.last = (i == n - 1);
            unescaped_q.push_back(w);
        end
    endfunction

    function automatic void unescape_byte(input logic [7:0] c);
        int          d;
        logic [3:0]  nib;
        logic [15:0] v;
        case (esc_phase)
            PH_ESC: begin
                esc_phase = PH_PLAIN;
                case (c)
                    CH_QUOTE, CH_BSLASH, CH_SLASH: emit(1, KIND_DATA, c, 8'h00, 8'h00);
                    CH_B: emit(1, KIND_DATA, CTL_BS, 8'h00, 8'h00);
                    CH_F: emit(1, KIND_DATA, CTL_FF, 8'h00, 8'h00);
                    CH_N: emit(1, KIND_DATA, CTL_LF, 8'h00, 8'h00);
                    CH_R: emit(1, KIND_DATA, CTL_CR, 8'h00, 8'h00);
                    CH_T: emit(1, KIND_DATA, CTL_TAB, 8'h00, 8'h00);
                    CH_U: begin
                        esc_phase = PH_HEX1;
                        hex_acc   = '0;
                    end
                    default: begin
                        hex_acc = '0;
                        emit(1, KIND_ERR, 8'h00, 8'h00, 8'h00);
                    end
                endcase
            end
            PH_HEX1, PH_HEX2, PH_HEX3, PH_HEX4: begin
                d = hex_digit(c);
                if (d < 0) begin
                    esc_phase = PH_PLAIN;
                    hex_acc   = '0;
                    emit(1, KIND_ERR, 8'h00, 8'h00, 8'h00);
                end else begin
                    nib = d[3:0];
                    if (esc_phase != PH_HEX4) begin
                        hex_acc   = {hex_acc[7:0], nib};
                        esc_phase = phase_t'(esc_phase + 3'd1);
                    end else begin
                        // Fourth digit: encode the code value as UTF-8
                        v         = {hex_acc, nib};
                        esc_phase = PH_PLAIN;
                        hex_acc   = '0;
                        if (v < 16'h0080)
                            emit(1, KIND_DATA, v[7:0], 8'h00, 8'h00);
                        else if (v < 16'h0800)
                            emit(2, KIND_DATA, {3'b110, v[10:6]}, {2'b10, v[5:0]}, 8'h00);
                        else
                            emit(3, KIND_DATA, {4'b1110, v[15:12]}, {2'b10, v[11:6]},
                                 {2'b10, v[5:0]});
                    end
                end
            end
            default: begin
                esc_phase = PH_PLAIN;
                if (c == CH_BSLASH) begin
                    esc_phase = PH_ESC;
                end else if (c == CH_QUOTE) begin
                    hex_acc = '0;
                    emit(1, KIND_END, 8'h00, 8'h00, 8'h00);
                end else begin
                    emit(1, KIND_DATA, c, 8'h00, 8'h00);
                end
            end
        endcase
    endfunction

    // ---------------------------------------------------------------
    // Driver: offers queued bytes, predicts on each accepted word
    // ---------------------------------------------------------------
    always @(posedge aclk) begin : tx_driver
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                unescape_byte(s_tdata);
                bytes_accepted++;
            end
            if (!s_tvalid || s_tready) begin
                if (string_bytes.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= string_bytes.pop_front();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Monitor: checks each result word against the oldest prediction
    // ---------------------------------------------------------------
    always @(posedge aclk) begin : rx_monitor
        out_word_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (unescaped_q.size() == 0) begin
                    flag_mismatch($sformatf("unexpected word data=%02h kind=%0d last=%0b",
                                            m_tdata, m_tuser, m_tlast));
                end else begin
                    want = unescaped_q.pop_front();
                    if (m_tdata !== want.data)
                        flag_mismatch($sformatf("out_byte %02h, predicted %02h",
                                                m_tdata, want.data));
                    if (m_tuser !== want.kind)
                        flag_mismatch($sformatf("kind %0d, predicted %0d",
                                                m_tuser, want.kind));
                    if (m_tlast !== want.last)
                        flag_mismatch($sformatf("last %0b, predicted %0b",
                                                m_tlast, want.last));
                end
            end
            m_tready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Long receiver hold-off so the block backs up and stalls its input
    initial begin : rx_holdoff
        wait (holdoff_armed);
        @(posedge aclk);
        rx_hold <= 1'b1;
        repeat (HOLDOFF_CYCLES) @(posedge aclk);
        rx_hold <= 1'b0;
    end

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------

    function automatic void add_byte(input logic [7:0] b);
        string_bytes.push_back(b);
        bytes_queued++;
    endfunction

    function automatic logic [7:0] short_esc_char(input int idx);
        case (idx)
            0: return CH_QUOTE;
            1: return CH_BSLASH;
            2: return CH_SLASH;
            3: return CH_B;
            4: return CH_F;
            5: return CH_N;
            6: return CH_R;
            default: return CH_T;
        endcase
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n, input logic up);
        if (n < 4'd10)
            return CH_0 + 8'(n);
        return (up ? CH_UA : CH_LA) + 8'(n - 4'd10);
    endfunction

    // \u escape with four digits; uppercase letters where allowed, now and then otherwise
    function automatic void add_unicode(input logic [15:0] code);
        logic up;
        add_byte(CH_BSLASH);
        add_byte(CH_U);
        for (int i = 3; i >= 0; i--) begin
            up = upper_ok ? 1'($urandom_range(1)) : ($urandom_range(19) == 0);
            add_byte(hex_char(code[i*4 +: 4], up));
        end
    endfunction

    // One random sequence: mostly well-formed escapes and text, some broken ones
    function automatic void add_random_seq();
        int unsigned pick;
        int unsigned bad_pos;
        logic [15:0] code;
        logic [7:0]  b;
        pick = $urandom_range(99);
        if (pick < 35) begin
            b = 8'($urandom_range(255));
            if (b == CH_BSLASH)
                b = 8'($urandom_range(8'h5B, 8'h23));
            add_byte(b);
        end else if (pick < 50) begin
            add_byte(CH_BSLASH);
            add_byte(short_esc_char($urandom_range(7)));
        end else if (pick < 78) begin
            case ($urandom_range(4))
                0: code = 16'($urandom_range(16'h007F));
                1: code = 16'($urandom_range(16'h07FF, 16'h0080));
                2: code = 16'($urandom_range(16'hFFFF, 16'h0800));
                3: code = 16'($urandom_range(16'hDFFF, 16'hD800));
                default: begin
                    case ($urandom_range(5))
                        0: code = 16'h0000;
                        1: code = 16'h007F;
                        2: code = 16'h0080;
                        3: code = 16'h07FF;
                        4: code = 16'h0800;
                        default: code = 16'hFFFF;
                    endcase
                end
            endcase
            add_unicode(code);
        end else if (pick < 84) begin
            add_byte(CH_QUOTE);
        end else if (pick < 91) begin
            // escape letter that is not one, ASCII or not
            do begin
                b = 8'($urandom_range(255));
            end while (b == CH_QUOTE || b == CH_BSLASH || b == CH_SLASH || b == CH_B ||
                       b == CH_F || b == CH_N || b == CH_R || b == CH_T || b == CH_U);
            add_byte(CH_BSLASH);
            add_byte(b);
        end else if (pick < 97) begin
            // \u cut short by a byte that is not an accepted digit
            bad_pos = $urandom_range(3);
            add_byte(CH_BSLASH);
            add_byte(CH_U);
            for (int i = 0; i < int'(bad_pos); i++)
                add_byte(hex_char(4'($urandom_range(15)), upper_ok));
            do begin
                b = 8'($urandom_range(255));
            end while (hex_digit(b) >= 0);
            add_byte(b);
        end else begin
            for (int i = 0; i <= int'($urandom_range(2)); i++)
                add_byte(8'($urandom_range(255)));
        end
    endfunction

    function automatic void feed_random(input int unsigned count);
        int unsigned start;
        start = bytes_queued;
        while (bytes_queued - start < count)
            add_random_seq();
    endfunction

    // Sender waits until every byte is taken and every result word has come
    task automatic settle();
        while (bytes_accepted != bytes_queued || unescaped_q.size() != 0)
            @(posedge aclk);
        repeat (IDLE_SETTLE) @(posedge aclk);
    endtask

    task automatic write_mode(input logic upper);
        @(posedge aclk);
        cfg_wvalid <= 1'b1;
        cfg_wdata  <= upper;
        do @(posedge aclk); while (!cfg_wready);
        cfg_wvalid <= 1'b0;
        upper_ok = upper;
    endtask

    // ---------------------------------------------------------------
    // Test sequence
    // ---------------------------------------------------------------
    initial begin : stimulus
        int unsigned waited;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: byte extremes, every short escape, \u0000, non-ASCII escape, end
        tx_idle_pct  = 18;
        rx_stall_pct = 65;
        write_mode(1'b0);
        add_byte(8'h00);
        add_byte(8'hFF);
        for (int i = 0; i < 8; i++) begin
            add_byte(CH_BSLASH);
            add_byte(short_esc_char(i));
        end
        add_unicode(16'h0000);
        add_byte(CH_BSLASH);
        add_byte(8'h80);
        add_byte(CH_QUOTE);
        settle();

        // Uppercase digits allowed; the sender pauses for all results midway
        write_mode(1'b1);
        feed_random(80);
        settle();
        feed_random(80);
        settle();

        // Receiver quiet, sender slow, lowercase only
        tx_idle_pct  = 65;
        rx_stall_pct = 18;
        write_mode(1'b0);
        feed_random(160);
        settle();

        // Full rate, with one long receiver hold-off
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        write_mode(1'b1);
        feed_random(160);
        holdoff_armed = 1'b1;
        while (bytes_accepted != bytes_queued)
            @(posedge aclk);

        waited = 0;
        while (unescaped_q.size() != 0 && waited < FINAL_WAIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (IDLE_SETTLE) @(posedge aclk);
        if (unescaped_q.size() != 0)
            flag_mismatch($sformatf("%0d predicted words never came", unescaped_q.size()));

        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

### files.f
+incdir+src
src/jsu_pkg.sv
src/jsu_decode.sv
src/jsu_out_buf.sv
src/json_string_unescape_core.sv
src/jsu_checker.sv
tb/sv/json_string_unescape_core_tb.sv
